### hdl/ttip_pkg.sv
// Shared types, character codes and helper functions for the text to integer parser.
// No dependencies; used by ttip_core and text_to_integer_parser_unit.
package ttip_pkg;

    localparam int VALUE_BITS_DEF = 32;  // default accumulator width
    localparam int VALUE_OUT_BITS = 32;  // width of the value field in a result word
    localparam int CHAR_BITS      = 16;  // width of a wide character
    localparam int COUNT_BITS     = 16;  // width of the digit count

    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 16'h0030;
    localparam logic [CHAR_BITS-1:0] CH_NINE  = 16'h0039;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 16'h002D;
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 16'h002B;
    localparam logic [CHAR_BITS-1:0] CH_X_LO  = 16'h0078;
    localparam logic [CHAR_BITS-1:0] CH_X_UP  = 16'h0058;
    localparam logic [CHAR_BITS-1:0] CH_A_LO  = 16'h0061;
    localparam logic [CHAR_BITS-1:0] CH_Z_LO  = 16'h007A;
    localparam logic [CHAR_BITS-1:0] CH_A_UP  = 16'h0041;
    localparam logic [CHAR_BITS-1:0] CH_Z_UP  = 16'h005A;

    localparam logic [5:0] NO_DIGIT = 6'h3F;

    // base_select codes
    typedef enum logic [1:0] {
        BASE_AUTO,
        BASE_OCT,
        BASE_DEC,
        BASE_HEX
    } base_t;

    // One parsed number as it leaves the block.
    typedef struct packed {
        logic [VALUE_OUT_BITS-1:0] value;
        logic                      is_negative;
        logic [COUNT_BITS-1:0]     digit_count;
        logic                      status;
        logic [CHAR_BITS-1:0]      stop_character;
        logic                      ended_by_text_end;
    } result_t;

    function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
        return (c == 16'h0020) || (c == 16'h0009) || (c == 16'h000A) ||
               (c == 16'h000D) || (c == 16'h000C) || (c == 16'h000B);
    endfunction

    // Digit value of 0-9, a-z, A-Z; NO_DIGIT for anything else.
    function automatic logic [5:0] digit_value(input logic [CHAR_BITS-1:0] c);
        logic [5:0] d;
        d = NO_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE)
            d = 6'(c[6:0] - 7'h30);
        else if (c >= CH_A_LO && c <= CH_Z_LO)
            d = 6'(c[6:0] - 7'h57);
        else if (c >= CH_A_UP && c <= CH_Z_UP)
            d = 6'(c[6:0] - 7'h37);
        return d;
    endfunction

endpackage

### hdl/ttip_core.sv
// Parse state machine and shift-add accumulator: one character per enabled cycle.
// Depends on ttip_pkg.
module ttip_core #(
    parameter int VALUE_BITS = ttip_pkg::VALUE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step_en,
    input  logic                           kind,
    input  logic [ttip_pkg::CHAR_BITS-1:0] character,
    input  logic [1:0]                     base_select,
    output logic                           emit,
    output ttip_pkg::result_t              result
);

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_SIGN,
        PH_ZERO,
        PH_DIGITS
    } phase_t;

    localparam int OUT_BITS = ttip_pkg::VALUE_OUT_BITS;
    localparam int CNT_BITS = ttip_pkg::COUNT_BITS;

    phase_t                phase_reg, phase_next;
    ttip_pkg::base_t       base_reg, base_next;
    logic                  minus_reg, minus_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [CNT_BITS-1:0]   digits_reg, digits_next;

    ttip_pkg::base_t       base_eff;
    ttip_pkg::base_t       step_base;
    logic [VALUE_BITS-1:0] step_acc;
    logic [CNT_BITS-1:0]   step_digits;
    logic                  do_step;
    logic [5:0]            dval;
    logic [5:0]            radix;
    logic [VALUE_BITS-1:0] scaled;
    logic [VALUE_BITS-1:0] emit_acc;
    logic [CNT_BITS-1:0]   emit_digits;
    logic [VALUE_BITS-1:0] signed_acc;
    logic [ttip_pkg::CHAR_BITS-1:0] stop_char;
    logic                  at_end;

    assign dval = ttip_pkg::digit_value(character);

    always_comb
    begin
        base_eff    = (phase_reg == PH_SKIP) ? ttip_pkg::base_t'(base_select) : base_reg;
        phase_next  = phase_reg;
        base_next   = base_eff;
        minus_next  = minus_reg;
        acc_next    = acc_reg;
        digits_next = digits_reg;
        step_base   = base_eff;
        step_acc    = acc_reg;
        step_digits = digits_reg;
        do_step     = 1'b0;
        emit        = 1'b0;
        emit_acc    = acc_reg;
        emit_digits = digits_reg;
        stop_char   = character;
        at_end      = 1'b0;
        radix       = 6'd10;
        scaled      = '0;

        if (kind)
        begin
            emit      = 1'b1;
            at_end    = 1'b1;
            stop_char = '0;
            // a pending leading zero is a complete number of one digit
            if (phase_reg == PH_ZERO)
            begin
                emit_acc    = '0;
                emit_digits = CNT_BITS'(1);
            end
        end
        else
        begin
            unique case (phase_reg) inside
                PH_SKIP, PH_SIGN:
                begin
                    if (phase_reg == PH_SKIP && ttip_pkg::is_space(character))
                    begin
                        phase_next = PH_SKIP;
                    end
                    else if (phase_reg == PH_SKIP && character == ttip_pkg::CH_MINUS)
                    begin
                        minus_next = 1'b1;
                        phase_next = PH_SIGN;
                    end
                    else if (phase_reg == PH_SKIP && character == ttip_pkg::CH_PLUS)
                    begin
                        phase_next = PH_SIGN;
                    end
                    else if (character == ttip_pkg::CH_ZERO &&
                             (base_eff == ttip_pkg::BASE_AUTO ||
                              base_eff == ttip_pkg::BASE_HEX))
                    begin
                        phase_next = PH_ZERO;
                    end
                    else
                    begin
                        step_base = (base_eff == ttip_pkg::BASE_AUTO) ? ttip_pkg::BASE_DEC
                                                                       : base_eff;
                        base_next = step_base;
                        do_step   = 1'b1;
                    end
                end
                PH_ZERO:
                begin
                    if (character == ttip_pkg::CH_X_LO || character == ttip_pkg::CH_X_UP)
                    begin
                        base_next   = ttip_pkg::BASE_HEX;
                        acc_next    = '0;
                        digits_next = '0;
                        phase_next  = PH_DIGITS;
                    end
                    else
                    begin
                        // the zero itself counts as a digit
                        step_base   = (base_eff == ttip_pkg::BASE_AUTO) ? ttip_pkg::BASE_OCT
                                                                         : base_eff;
                        base_next   = step_base;
                        step_acc    = '0;
                        step_digits = CNT_BITS'(1);
                        emit_acc    = '0;
                        emit_digits = CNT_BITS'(1);
                        do_step     = 1'b1;
                    end
                end
                PH_DIGITS:
                begin
                    do_step = 1'b1;
                end
                default:
                begin
                    do_step = 1'b0;
                end
            endcase

            case (step_base)
                ttip_pkg::BASE_OCT:
                begin
                    radix  = 6'd8;
                    scaled = step_acc << 3;
                end
                ttip_pkg::BASE_HEX:
                begin
                    radix  = 6'd16;
                    scaled = step_acc << 4;
                end
                default:
                begin
                    radix  = 6'd10;
                    scaled = (step_acc << 3) + (step_acc << 1);
                end
            endcase

            if (do_step)
            begin
                if (dval < radix)
                begin
                    acc_next    = scaled + {{(VALUE_BITS-4){1'b0}}, dval[3:0]};
                    digits_next = (step_digits == '1) ? step_digits
                                                      : step_digits + CNT_BITS'(1);
                    phase_next  = PH_DIGITS;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
        end

        // drop the number once it is reported
        if (emit)
        begin
            phase_next  = PH_SKIP;
            base_next   = ttip_pkg::BASE_AUTO;
            minus_next  = 1'b0;
            acc_next    = '0;
            digits_next = '0;
        end
    end

    assign signed_acc = minus_reg ? (~emit_acc + VALUE_BITS'(1)) : emit_acc;

    generate
        if (VALUE_BITS >= OUT_BITS)
        begin : g_value_trunc
            assign result.value = signed_acc[OUT_BITS-1:0];
        end
        else
        begin : g_value_ext
            assign result.value = {{(OUT_BITS-VALUE_BITS){1'b0}}, signed_acc};
        end
    endgenerate

    assign result.is_negative       = minus_reg;
    assign result.digit_count       = emit_digits;
    assign result.status            = (emit_digits == '0);
    assign result.stop_character    = stop_char;
    assign result.ended_by_text_end = at_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SKIP;
            base_reg   <= ttip_pkg::BASE_AUTO;
            minus_reg  <= 1'b0;
            acc_reg    <= '0;
            digits_reg <= '0;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            base_reg   <= base_next;
            minus_reg  <= minus_next;
            acc_reg    <= acc_next;
            digits_reg <= digits_next;
        end
    end

endmodule

### hdl/text_to_integer_parser_unit.sv
// Top level of the streaming text to integer parser: input and result registers around ttip_core.
// Depends on ttip_pkg and ttip_core.

// The parser takes one wide character per word and turns runs of text into integers the
// way strtol does: leading whitespace is skipped, one '+' or '-' is taken, "0x"/"0X" is
// recognized in auto and hex mode, and a leading zero selects octal in auto mode. Digits
// below the base are accumulated modulo 2^VALUE_BITS. The first character that is not a
// digit, or an end-of-text word (s_tuser high), ends the number and produces exactly one
// result word; the stopping character is reported and dropped, it does not start the next
// number. Words that do not end a number produce no result. base_select is sampled with
// every word taken while whitespace is being skipped. Rate: one word per clock, sustained;
// words that do not end a number keep flowing while a result waits, and only a word that
// ends a number holds while the previous result is still unread. The figure is set by the
// parse state loop, which closes through the shift-add accumulator (x8, x10 or x16 plus
// digit). An accepted input word passes through the input register and the core's
// combinational step into the result register on the output.
module text_to_integer_parser_unit #(
    parameter int VALUE_BITS = ttip_pkg::VALUE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] character, [17:16] base_select, [23:18] zero
    input  logic        s_tuser,   // [0] kind (1 = end of text)
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [31:0] value, [32] is_negative, [48:33] digit_count,
                                   // [64:49] stop_character, [71:65] zero
    output logic [1:0]  m_tuser    // [0] status, [1] ended_by_text_end
);

    localparam int CB = ttip_pkg::CHAR_BITS;

    // input register
    logic          in_valid_reg, in_valid_next;
    logic          in_kind_reg;
    logic [CB-1:0] in_char_reg;
    logic [1:0]    in_base_reg;

    // result register
    logic               out_valid_reg, out_valid_next;
    ttip_pkg::result_t  out_data_reg;

    logic               advance;
    logic               emit;
    ttip_pkg::result_t  result;

    // Advance the held word unless it ends a number while the result register is
    // full and not being emptied.
    assign advance  = in_valid_reg && (!emit || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    ttip_core #(
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .kind        (in_kind_reg),
        .character   (in_char_reg),
        .base_select (in_base_reg),
        .emit        (emit),
        .result      (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        // hold a result until taken; load a new one when an advancing word makes the core emit
        out_valid_next = out_valid_reg && !m_tready;
        if (advance && emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers need no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg <= s_tuser;
            in_char_reg <= s_tdata[CB-1:0];
            in_base_reg <= s_tdata[CB+1:CB];
        end
        if (advance && emit)
            out_data_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0,
                       out_data_reg.stop_character,
                       out_data_reg.digit_count,
                       out_data_reg.is_negative,
                       out_data_reg.value};
    assign m_tuser  = {out_data_reg.ended_by_text_end, out_data_reg.status};

    // no digits means a zero value
    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[31:0] == 32'd0)
        else $error("empty number reported with nonzero value");

    // status and digit count agree
    a_status_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[0] == (m_tdata[48:33] == 16'd0)))
        else $error("status disagrees with digit count");

    // end of text reports a zero stop character
    a_end_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata[64:49] == 16'd0)
        else $error("end of text reported with a stop character");

    // a held word that cannot advance is not lost
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_char_reg))
        else $error("input word dropped while stalled");

endmodule

### tb/sv/text_to_integer_parser_unit_test.sv
// Self-checking testbench for text_to_integer_parser_unit: directed table, then random text.
// Depends on ttip_pkg and the text_to_integer_parser_unit RTL; needs no files or arguments.
`timescale 1ns / 1ps

module text_to_integer_parser_unit_test;

    // Parse phases, as the predictor tracks them.
    typedef enum logic [1:0] {PH_BLANK, PH_SIGN, PH_ZERO, PH_DIGITS} parse_phase_t;

    localparam bit KIND_CHAR = 1'b0;
    localparam bit KIND_END  = 1'b1;

    // Whitespace and a few other characters the directed table uses.
    localparam logic [15:0] CH_NUL   = 16'h0000;
    localparam logic [15:0] CH_TAB   = 16'h0009;
    localparam logic [15:0] CH_LF    = 16'h000A;
    localparam logic [15:0] CH_VT    = 16'h000B;
    localparam logic [15:0] CH_FF    = 16'h000C;
    localparam logic [15:0] CH_CR    = 16'h000D;
    localparam logic [15:0] CH_SPACE = 16'h0020;
    localparam logic [15:0] CH_BANG  = 16'h0021;
    localparam logic [15:0] CH_G_LO  = 16'h0067;
    localparam logic [15:0] CH_MAX   = 16'hFFFF;

    localparam int unsigned NOT_A_DIGIT  = 99;
    localparam int unsigned RANDOM_WORDS = 1700;
    localparam int unsigned DRAIN_CYCLES = 16;      // watch for stray results after the drain
    // Watchdog limit for the whole run of about 1.8k words, input gaps and result stalls included.
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned N_DIRECTED   = 27;

    typedef struct {
        bit                kind;
        logic [15:0]       ch;
        logic [1:0]        bsel;
        bit                typed;   // want holds a hand-written expectation
        ttip_pkg::result_t want;
    } stim_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // [15:0] character, [17:16] base_select, [23:18] zero
    logic        s_tuser  = 1'b0; // [0] kind (1 = end of text)
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;         // [31:0] value, [32] is_negative, [48:33] digit_count,
                                  // [64:49] stop_character, [71:65] zero
    logic [1:0]  m_tuser;         // [0] status, [1] ended_by_text_end

    text_to_integer_parser_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // Predictor state: one number in progress.
    parse_phase_t    ph      = PH_BLANK;
    ttip_pkg::base_t base    = ttip_pkg::BASE_AUTO;
    bit              neg     = 1'b0;
    logic [31:0]     acc     = '0;
    logic [15:0]     ndig    = '0;

    ttip_pkg::result_t numbers_due[$];   // parsed numbers still owed by the block
    stim_row_t         directed_words[N_DIRECTED];

    int unsigned  errors          = 0;
    int unsigned  words_counted   = 0;
    int unsigned  numbers_checked = 0;
    int unsigned  ended_by_end    = 0;
    int unsigned  empty_numbers   = 0;
    int unsigned  cycles          = 0;
    int unsigned  burst_left      = 0;

    function automatic bit char_is_blank(input logic [15:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
               c == CH_FF || c == CH_VT;
    endfunction

    function automatic int unsigned char_digit(input logic [15:0] c);
        if (c >= ttip_pkg::CH_ZERO && c <= ttip_pkg::CH_NINE)
            return c - ttip_pkg::CH_ZERO;
        if (c >= ttip_pkg::CH_A_LO && c <= ttip_pkg::CH_Z_LO)
            return c - ttip_pkg::CH_A_LO + 10;
        if (c >= ttip_pkg::CH_A_UP && c <= ttip_pkg::CH_Z_UP)
            return c - ttip_pkg::CH_A_UP + 10;
        return NOT_A_DIGIT;
    endfunction

    function automatic int unsigned radix_of(input ttip_pkg::base_t b);
        if (b == ttip_pkg::BASE_OCT)
            return 8;
        if (b == ttip_pkg::BASE_HEX)
            return 16;
        return 10;
    endfunction

    // Character for digit value d, letters in either case.
    function automatic logic [15:0] digit_char(input int unsigned d);
        if (d < 10)
            return ttip_pkg::CH_ZERO + 16'(d);
        if ($urandom_range(0, 1) == 0)
            return ttip_pkg::CH_A_LO + 16'(d - 10);
        return ttip_pkg::CH_A_UP + 16'(d - 10);
    endfunction

    function automatic logic [15:0] blank_char();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            3: return CH_CR;
            4: return CH_FF;
            default: return CH_VT;
        endcase
    endfunction

    function automatic ttip_pkg::result_t mk(input logic [31:0] value, input bit is_neg,
                                             input logic [15:0] count, input bit status,
                                             input logic [15:0] stop, input bit at_end);
        ttip_pkg::result_t r;
        r.value             = value;
        r.is_negative       = is_neg;
        r.digit_count       = count;
        r.status            = status;
        r.stop_character    = stop;
        r.ended_by_text_end = at_end;
        return r;
    endfunction

    function automatic stim_row_t word_row(input bit kind, input logic [15:0] ch,
                                           input ttip_pkg::base_t bsel, input bit typed,
                                           input ttip_pkg::result_t want);
        stim_row_t r;
        r.kind  = kind;
        r.ch    = ch;
        r.bsel  = bsel;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // Finish the number in progress and start over.
    task automatic close_number(input logic [15:0] stop, input bit at_end,
                                output ttip_pkg::result_t res);
        res = mk(neg ? -acc : acc, neg, ndig, ndig == 0, stop, at_end);
        ph   = PH_BLANK;
        base = ttip_pkg::BASE_AUTO;
        neg  = 1'b0;
        acc  = '0;
        ndig = '0;
    endtask

    // Advance the predictor by one accepted word.
    task automatic parse_word(input bit kind, input logic [15:0] ch, input logic [1:0] bsel,
                              output bit emits, output ttip_pkg::result_t res);
        int unsigned d;
        int unsigned r;
        bit          take_digit;
        emits = 1'b0;
        res   = '0;
        if (ph == PH_BLANK)
            base = ttip_pkg::base_t'(bsel);
        if (kind == KIND_END)
        begin
            // a lone leading zero still counts as one digit
            if (ph == PH_ZERO)
            begin
                acc  = '0;
                ndig = 16'd1;
            end
            close_number(CH_NUL, 1'b1, res);
            emits = 1'b1;
        end
        else if (ph == PH_BLANK && char_is_blank(ch))
        begin
        end
        else if (ph == PH_BLANK && ch == ttip_pkg::CH_MINUS)
        begin
            neg = 1'b1;
            ph  = PH_SIGN;
        end
        else if (ph == PH_BLANK && ch == ttip_pkg::CH_PLUS)
        begin
            ph = PH_SIGN;
        end
        else if (ph == PH_BLANK || ph == PH_SIGN)
        begin
            if (ch == ttip_pkg::CH_ZERO &&
                (base == ttip_pkg::BASE_AUTO || base == ttip_pkg::BASE_HEX))
            begin
                ph = PH_ZERO;
            end
            else
            begin
                if (base == ttip_pkg::BASE_AUTO)
                    base = ttip_pkg::BASE_DEC;
                d = char_digit(ch);
                if (d < radix_of(base))
                begin
                    acc  = 32'(d);
                    ndig = 16'd1;
                    ph   = PH_DIGITS;
                end
                else
                begin
                    close_number(ch, 1'b0, res);
                    emits = 1'b1;
                end
            end
        end
        else
        begin
            take_digit = 1'b1;
            if (ph == PH_ZERO)
            begin
                acc = '0;
                ph  = PH_DIGITS;
                if (ch == ttip_pkg::CH_X_LO || ch == ttip_pkg::CH_X_UP)
                begin
                    // hex prefix: the zero does not count as a digit
                    base       = ttip_pkg::BASE_HEX;
                    ndig       = '0;
                    take_digit = 1'b0;
                end
                else
                begin
                    if (base == ttip_pkg::BASE_AUTO)
                        base = ttip_pkg::BASE_OCT;
                    ndig = 16'd1;
                end
            end
            if (take_digit)
            begin
                d = char_digit(ch);
                r = radix_of(base);
                if (d < r)
                begin
                    acc = 32'(acc * r + d);
                    if (ndig != 16'hFFFF)
                        ndig = ndig + 16'd1;
                end
                else
                begin
                    close_number(ch, 1'b0, res);
                    emits = 1'b1;
                end
            end
        end
    endtask

    // Offer one word; hold it until the handshake, then predict its outcome.
    task automatic send_word(input bit kind, input logic [15:0] ch, input logic [1:0] bsel,
                             input bit typed, input ttip_pkg::result_t want);
        bit                emits;
        ttip_pkg::result_t res;
        int unsigned       gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, bsel, ch};
        s_tuser  <= kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_counted++;
        parse_word(kind, ch, bsel, emits, res);
        if (typed)
            numbers_due.push_back(want);
        else if (emits)
            numbers_due.push_back(res);
    endtask

    // Drop valid and wait until every owed number has come out.
    task automatic pause_until_drained();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (numbers_due.size() != 0);
    endtask

    // One well-formed number with random content: blanks, sign, prefix, digits, terminator.
    task automatic send_number();
        logic [1:0]  bsel;
        int unsigned n;
        int unsigned radix;
        int unsigned i;
        int unsigned pick;
        bit          hex_pfx;
        bit          oct_pfx;
        logic [1:0]  later_bsel;
        bsel = 2'($urandom_range(0, 3));
        n    = $urandom_range(0, 3);
        for (i = 0; i < n; i++)
            send_word(KIND_CHAR, blank_char(), bsel, 1'b0, '0);
        pick = $urandom_range(0, 2);
        if (pick == 1)
            send_word(KIND_CHAR, ttip_pkg::CH_PLUS, bsel, 1'b0, '0);
        else if (pick == 2)
            send_word(KIND_CHAR, ttip_pkg::CH_MINUS, bsel, 1'b0, '0);
        hex_pfx = (bsel == ttip_pkg::BASE_AUTO || bsel == ttip_pkg::BASE_HEX) &&
                  $urandom_range(0, 2) == 0;
        oct_pfx = !hex_pfx && bsel == ttip_pkg::BASE_AUTO && $urandom_range(0, 3) == 0;
        if (hex_pfx || oct_pfx)
            send_word(KIND_CHAR, ttip_pkg::CH_ZERO, bsel, 1'b0, '0);
        if (hex_pfx)
            send_word(KIND_CHAR, $urandom_range(0, 1) ? ttip_pkg::CH_X_LO : ttip_pkg::CH_X_UP,
                      bsel, 1'b0, '0);
        if (hex_pfx)
            radix = 16;
        else if (oct_pfx)
            radix = 8;
        else if (bsel == ttip_pkg::BASE_AUTO)
            radix = 10;
        else
            radix = radix_of(ttip_pkg::base_t'(bsel));
        // mostly short numbers, some long enough to wrap the value
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 12);
        for (i = 0; i < n; i++)
        begin
            // base_select only matters while blanks are skipped; vary it now and then
            later_bsel = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : bsel;
            send_word(KIND_CHAR, digit_char($urandom_range(0, radix - 1)), later_bsel,
                      1'b0, '0);
        end
        pick = $urandom_range(0, 7);
        if (pick < 4)
            send_word(KIND_END, 16'($urandom), bsel, 1'b0, '0);
        else if (pick == 4)
            send_word(KIND_CHAR, 16'($urandom), bsel, 1'b0, '0);
        else if (pick == 5 && radix < 36)
            send_word(KIND_CHAR, digit_char($urandom_range(radix, 35)), bsel, 1'b0, '0);
        else if (pick == 6)
            send_word(KIND_CHAR, blank_char(), bsel, 1'b0, '0);
        else
            send_word(KIND_CHAR, 16'($urandom_range(16'h0020, 16'h007E)), bsel, 1'b0, '0);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Unpack one result word and hold it against the oldest owed number.
    task automatic check_number();
        ttip_pkg::result_t got;
        ttip_pkg::result_t want;
        got.value             = m_tdata[31:0];
        got.is_negative       = m_tdata[32];
        got.digit_count       = m_tdata[48:33];
        got.stop_character    = m_tdata[64:49];
        got.status            = m_tuser[0];
        got.ended_by_text_end = m_tuser[1];
        if (numbers_due.size() == 0)
        begin
            $display("%0t: result word with nothing expected: expected none, actual %h",
                     $time, got);
            errors++;
        end
        else
        begin
            want = numbers_due.pop_front();
            numbers_checked++;
            if (want.ended_by_text_end)
                ended_by_end++;
            if (want.status)
                empty_numbers++;
            compare_field("value", want.value, got.value);
            compare_field("is_negative", 32'(want.is_negative), 32'(got.is_negative));
            compare_field("digit_count", 32'(want.digit_count), 32'(got.digit_count));
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("stop_character", 32'(want.stop_character),
                          32'(got.stop_character));
            compare_field("ended_by_text_end", 32'(want.ended_by_text_end),
                          32'(got.ended_by_text_end));
        end
    endtask

    // Receiver: switch between always ready, random ready and long stall stretches.
    int unsigned rx_seg_left  = 0;
    int unsigned rx_hold_left = 0;
    int unsigned rx_mode      = 0;
    bit          rx_level     = 1'b0;

    always @(posedge clk)
    begin
        if (rx_seg_left == 0)
        begin
            rx_seg_left = $urandom_range(20, 300);
            rx_mode     = $urandom_range(0, 2);
        end
        rx_seg_left--;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (rx_hold_left == 0)
                begin
                    rx_level     = !rx_level;
                    rx_hold_left = rx_level ? $urandom_range(1, 10) : $urandom_range(1, 30);
                end
                rx_hold_left--;
                m_tready <= rx_level;
            end
        endcase
    end

    // Sample the result handshake as it stood just before this edge.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_number();
    end

    // Watchdog: end a run that hangs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d numbers outstanding", $time, numbers_due.size());
            $display("text_to_integer_parser_unit regression: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned i;
        int unsigned n;
        bit          paused_mid;
        paused_mid = 1'b0;

        // Directed words; expectations typed in where they are plain to see.
        directed_words[0]  = word_row(KIND_END,  CH_NUL, ttip_pkg::BASE_AUTO, 1'b1,
                                      mk(32'h0, 1'b0, 16'd0, 1'b1, CH_NUL, 1'b1));
        // a lone zero parses as one octal digit
        directed_words[1]  = word_row(KIND_CHAR, ttip_pkg::CH_ZERO, ttip_pkg::BASE_AUTO,
                                      1'b0, '0);
        directed_words[2]  = word_row(KIND_END,  CH_NUL, ttip_pkg::BASE_AUTO, 1'b1,
                                      mk(32'h0, 1'b0, 16'd1, 1'b0, CH_NUL, 1'b1));
        directed_words[3]  = word_row(KIND_CHAR, ttip_pkg::CH_MINUS, ttip_pkg::BASE_DEC,
                                      1'b0, '0);
        directed_words[4]  = word_row(KIND_CHAR, ttip_pkg::CH_ZERO + 16'd1,
                                      ttip_pkg::BASE_DEC, 1'b0, '0);
        directed_words[5]  = word_row(KIND_CHAR, CH_BANG, ttip_pkg::BASE_DEC, 1'b1,
                                      mk(32'hFFFF_FFFF, 1'b1, 16'd1, 1'b0, CH_BANG, 1'b0));
        // sign followed by whitespace has no digits
        directed_words[6]  = word_row(KIND_CHAR, ttip_pkg::CH_PLUS, ttip_pkg::BASE_AUTO,
                                      1'b0, '0);
        directed_words[7]  = word_row(KIND_CHAR, CH_SPACE, ttip_pkg::BASE_AUTO, 1'b1,
                                      mk(32'h0, 1'b0, 16'd0, 1'b1, CH_SPACE, 1'b0));
        // hex prefix with a non-hex character after it
        directed_words[8]  = word_row(KIND_CHAR, ttip_pkg::CH_ZERO, ttip_pkg::BASE_AUTO,
                                      1'b0, '0);
        directed_words[9]  = word_row(KIND_CHAR, ttip_pkg::CH_X_UP, ttip_pkg::BASE_AUTO,
                                      1'b0, '0);
        directed_words[10] = word_row(KIND_CHAR, CH_G_LO, ttip_pkg::BASE_AUTO, 1'b1,
                                      mk(32'h0, 1'b0, 16'd0, 1'b1, CH_G_LO, 1'b0));
        // auto octal; base_select is ignored once past the blanks
        directed_words[11] = word_row(KIND_CHAR, CH_TAB, ttip_pkg::BASE_AUTO, 1'b0, '0);
        directed_words[12] = word_row(KIND_CHAR, ttip_pkg::CH_ZERO, ttip_pkg::BASE_AUTO,
                                      1'b0, '0);
        directed_words[13] = word_row(KIND_CHAR, ttip_pkg::CH_ZERO + 16'd7,
                                      ttip_pkg::BASE_DEC, 1'b0, '0);
        directed_words[14] = word_row(KIND_CHAR, ttip_pkg::CH_ZERO + 16'd8,
                                      ttip_pkg::BASE_HEX, 1'b0, '0);
        directed_words[15] = word_row(KIND_CHAR, CH_MAX, ttip_pkg::BASE_OCT, 1'b1,
                                      mk(32'h0, 1'b0, 16'd0, 1'b1, CH_MAX, 1'b0));
        // NUL is an ordinary non-digit
        directed_words[16] = word_row(KIND_CHAR, CH_NUL, ttip_pkg::BASE_DEC, 1'b1,
                                      mk(32'h0, 1'b0, 16'd0, 1'b1, CH_NUL, 1'b0));
        // in hex mode a zero without x is a plain digit
        directed_words[17] = word_row(KIND_CHAR, ttip_pkg::CH_ZERO, ttip_pkg::BASE_HEX,
                                      1'b0, '0);
        directed_words[18] = word_row(KIND_CHAR, ttip_pkg::CH_NINE, ttip_pkg::BASE_HEX,
                                      1'b0, '0);
        directed_words[19] = word_row(KIND_CHAR, ttip_pkg::CH_A_LO, ttip_pkg::BASE_HEX,
                                      1'b0, '0);
        directed_words[20] = word_row(KIND_END,  CH_MAX, ttip_pkg::BASE_HEX, 1'b0, '0);
        directed_words[21] = word_row(KIND_CHAR, ttip_pkg::CH_Z_LO, ttip_pkg::BASE_HEX, 1'b1,
                                      mk(32'h0, 1'b0, 16'd0, 1'b1, ttip_pkg::CH_Z_LO, 1'b0));
        // sign only, then end of text: no digits but the sign is reported
        directed_words[22] = word_row(KIND_CHAR, ttip_pkg::CH_MINUS, ttip_pkg::BASE_AUTO,
                                      1'b0, '0);
        directed_words[23] = word_row(KIND_END,  CH_MAX, ttip_pkg::BASE_AUTO, 1'b1,
                                      mk(32'h0, 1'b1, 16'd0, 1'b1, CH_NUL, 1'b1));
        // hex prefix cut off by end of text
        directed_words[24] = word_row(KIND_CHAR, ttip_pkg::CH_ZERO, ttip_pkg::BASE_HEX,
                                      1'b0, '0);
        directed_words[25] = word_row(KIND_CHAR, ttip_pkg::CH_X_LO, ttip_pkg::BASE_HEX,
                                      1'b0, '0);
        directed_words[26] = word_row(KIND_END,  CH_NUL, ttip_pkg::BASE_HEX, 1'b1,
                                      mk(32'h0, 1'b0, 16'd0, 1'b1, CH_NUL, 1'b1));

        // Hold reset low while the clock runs, then release it on an edge.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++)
            send_word(directed_words[i].kind, directed_words[i].ch, directed_words[i].bsel,
                      directed_words[i].typed, directed_words[i].want);
        pause_until_drained();

        // Random text: mostly well-formed numbers, some raw noise words.
        while (words_counted < N_DIRECTED + RANDOM_WORDS)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++)
                    send_word($urandom_range(0, 7) == 0, 16'($urandom),
                              2'($urandom_range(0, 3)), 1'b0, '0);
            end
            else
            begin
                send_number();
            end
            if (!paused_mid && words_counted >= N_DIRECTED + RANDOM_WORDS / 2)
            begin
                pause_until_drained();
                paused_mid = 1'b1;
            end
        end

        // Drain: wait for the owed numbers, then watch for strays.
        s_tvalid <= 1'b0;
        while (numbers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d words in %0d cycles; checked %0d numbers", words_counted,
                 cycles, numbers_checked);
        $display("(%0d ended by end of text, %0d without digits)",
                 ended_by_end, empty_numbers);
        if (errors == 0)
            $display("text_to_integer_parser_unit regression: pass");
        else
            $display("text_to_integer_parser_unit regression: fail");
        $finish;
    end

endmodule
